[sv/bilinear_density_grid_assert.svh]
// Assertion macros for the bilinear density grid.
// Both macros take a label, a clock, an active-low reset (the first one only),
// a property expression and a message.
`ifndef BILINEAR_DENSITY_GRID_ASSERT_SVH
`define BILINEAR_DENSITY_GRID_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BDG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BDG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BDG_ASSERT(lbl, clk, rst_n, prop, msg)

`define BDG_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[sv/bdg_pkg.sv]
`timescale 1ns / 1ps

package bdg_pkg;

  // fixed point format of densities and coordinates
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DENS_W    = 17;
  localparam logic [DENS_W-1:0] ONE_FX = DENS_W'(1) << FRAC_BITS;

  localparam int unsigned MAX_RES_DEF = 64;

  // field widths
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned ND_W    = 18;
  localparam int unsigned COORD_W = 17;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 24;

  // multiply-accumulate widths
  localparam int unsigned PROD_W = 2 * DENS_W;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_GET,
    ST_SPLIT,
    ST_SAMPLE
  } state_e;

  // sample sequencer steps: reads on 0..3, MAC on 1..6
  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_READ_LAST = 3'd3;
  localparam logic [2:0] STEP_TOP   = 3'd2;
  localparam logic [2:0] STEP_BOT   = 3'd4;
  localparam logic [2:0] STEP_BLEND = 3'd5;
  localparam logic [2:0] STEP_LAST  = 3'd6;

  typedef struct packed {
    logic en;       // update accumulator
    logic restart;  // drop old sum, start from this product
  } mac_ctrl_t;

endpackage

[sv/bilinear_density_grid.sv]
`timescale 1ns / 1ps
`include "bilinear_density_grid_assert.svh"
// Channel   Direction  Handshake            Payload
// s_axis    in         tvalid/tready        tuser: op; tdata: x, z, density, u, v
// m_axis    out        tvalid/tready        tuser: hit; tdata: density_out
// cfg       in         cfg_we_i (no wait)   grid_resolution
//
// Words run one at a time; the result goes valid as the block returns to idle,
//   before the next accept. Paced by the one-read-per-cycle grid memory
//   (four cell reads per sample) and the shared MAC (six products per sample).
// Reset and every resolution write run a clearing pass over all MAX_RES*MAX_RES
//   entries (4096 at default), one entry per cycle; no word is accepted then.
// A waiting result lets the next word in; that word holds at its last step.
module bilinear_density_grid import bdg_pkg::*; #(
  parameter int unsigned MAX_RES = MAX_RES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config: grid_resolution
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // input words
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] x_index, [31:16] z_index, [49:32] new_density, [66:50] u_coord,
  // [83:67] v_coord, [87:84] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] op
  input  logic [OP_W-1:0]        s_axis_tuser,
  // result words
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [16:0] density_out, [23:17] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] hit
  output logic                   m_axis_tuser
);

  localparam int unsigned DEPTH = MAX_RES * MAX_RES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = $clog2(MAX_RES);       // cell index
  localparam int unsigned RES_W = $clog2(MAX_RES + 1);   // resolution
  localparam int unsigned CW    = (RES_W > CFG_W) ? RES_W : CFG_W;
  localparam int unsigned PW    = IW + RES_W + 1;        // address product
  localparam int unsigned FXW   = COORD_W + RES_W;       // scaled coordinate

  // Field offsets in s_axis_tdata
  localparam int unsigned X_LSB  = 0;
  localparam int unsigned Z_LSB  = X_LSB + IDX_W;
  localparam int unsigned ND_LSB = Z_LSB + IDX_W;
  localparam int unsigned U_LSB  = ND_LSB + ND_W;
  localparam int unsigned V_LSB  = U_LSB + COORD_W;

  state_e state_q, state_d;

  logic [RES_W-1:0]  res_q;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [2:0]        step_q, step_d;

  // captured word
  logic [OP_W-1:0]    op_q;
  logic [IDX_W-1:0]   x_q, z_q;
  logic [ND_W-1:0]    nd_q;
  logic [COORD_W-1:0] u_q, v_q;

  // sample split
  logic [IW-1:0]        x0_q, z0_q;
  logic [FRAC_BITS-1:0] tx_q, tz_q;
  logic [DENS_W-1:0]    top_q, bot_q;

  // grid memory
  logic [DENS_W-1:0] mem [DEPTH];
  logic [DENS_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DENS_W-1:0] mem_wdata;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DENS_W-1:0] out_dens_q;
  logic              out_hit_q;

  logic              fin_req, fin_go, fin_hit;
  logic [DENS_W-1:0] fin_dens;

  logic in_accept;

  // ---------------------------------------------------------------------
  // Decode helpers
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]  res_wide;
  logic              in_range;
  logic [AW-1:0]     cell_addr;
  logic [DENS_W-1:0] set_val;
  logic [RES_W-1:0]  res_m1;

  assign res_wide = IDX_W'(res_q);
  assign in_range = (x_q < res_wide) && (z_q < res_wide);
  assign res_m1   = res_q - RES_W'(1);

  // entry of cell (x, z) is z * res + x; only used when in range
  assign cell_addr = AW'(PW'(z_q[IW-1:0]) * PW'(res_q) + PW'(x_q[IW-1:0]));

  // clamp signed density to [0, 1.0]
  always_comb begin
    if (nd_q[ND_W-1]) begin
      set_val = '0;
    end else if (nd_q[DENS_W-1:0] > ONE_FX) begin
      set_val = ONE_FX;
    end else begin
      set_val = nd_q[DENS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sample split: coordinate * (res - 1) into integer cell and fraction
  // ---------------------------------------------------------------------
  logic [COORD_W-1:0] uc, vc;
  logic [FXW-1:0]     fx, fz;

  assign uc = (u_q > COORD_W'(ONE_FX)) ? COORD_W'(ONE_FX) : u_q;
  assign vc = (v_q > COORD_W'(ONE_FX)) ? COORD_W'(ONE_FX) : v_q;
  assign fx = FXW'(uc) * FXW'(res_m1);
  assign fz = FXW'(vc) * FXW'(res_m1);

  // far neighbor, clamped to the last cell
  logic [RES_W-1:0] x0p1, z0p1;
  logic [IW-1:0]    x1, z1, xs, zs;
  logic [AW-1:0]    smp_addr;

  assign x0p1 = RES_W'(x0_q) + RES_W'(1);
  assign z0p1 = RES_W'(z0_q) + RES_W'(1);
  assign x1   = (x0p1 < res_m1) ? x0p1[IW-1:0] : res_m1[IW-1:0];
  assign z1   = (z0p1 < res_m1) ? z0p1[IW-1:0] : res_m1[IW-1:0];

  // read order: (x0,z0) (x1,z0) (x0,z1) (x1,z1)
  assign xs       = step_q[0] ? x1 : x0_q;
  assign zs       = step_q[1] ? z1 : z0_q;
  assign smp_addr = AW'(PW'(zs) * PW'(res_q) + PW'(xs));

  // ---------------------------------------------------------------------
  // Shared multiply-accumulate: two products per lerp, floored by shift
  // ---------------------------------------------------------------------
  mac_ctrl_t         mac_ctrl;
  logic [DENS_W-1:0] mac_a, mac_b;
  logic [PROD_W-1:0] mac_sum;
  logic [DENS_W-1:0] mac_floor;

  always_comb begin
    mac_a = rdata_q;
    mac_b = ONE_FX - DENS_W'(tx_q);
    if (step_q == STEP_BLEND) begin
      mac_a = top_q;
      mac_b = ONE_FX - DENS_W'(tz_q);
    end else if (step_q == STEP_LAST) begin
      mac_a = bot_q;
      mac_b = DENS_W'(tz_q);
    end else if (!step_q[0]) begin
      // second product of a row lerp
      mac_b = DENS_W'(tx_q);
    end
  end

  bdg_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .sum_o  (mac_sum)
  );

  assign mac_floor = mac_sum[FRAC_BITS +: DENS_W];

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign fin_go    = fin_req && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    step_d    = step_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (op_q == OP_GET && in_range) begin
          state_d = ST_GET;
        end else if (op_q == OP_SAMPLE && res_q != '0) begin
          state_d = ST_SPLIT;
        end else if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      ST_GET: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      ST_SPLIT: begin
        state_d = ST_SAMPLE;
        step_d  = STEP_FIRST;
      end
      ST_SAMPLE: begin
        if (step_q == STEP_LAST) begin
          if (fin_go) begin
            state_d = ST_IDLE;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    // a resolution write restarts the clearing pass
    if (cfg_we_i) begin
      state_d   = ST_CLEAR;
      clr_cnt_d = '0;
    end
  end

  // ---------------------------------------------------------------------
  // State outputs
  // ---------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_q;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = cell_addr;
    fin_req       = 1'b0;
    fin_dens      = '0;
    fin_hit       = 1'b0;
    mac_ctrl      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        s_axis_tready = !cfg_we_i;
      end
      ST_DECODE: begin
        unique case (op_q)
          OP_SET: begin
            fin_req = 1'b1;
            if (in_range) begin
              fin_dens  = set_val;
              fin_hit   = 1'b1;
              mem_we    = fin_go;
              mem_waddr = cell_addr;
              mem_wdata = set_val;
            end
          end
          OP_GET: begin
            if (in_range) begin
              mem_re = 1'b1;
            end else begin
              fin_req = 1'b1;
            end
          end
          OP_SAMPLE: begin
            fin_req = (res_q == '0);
          end
          default: begin
            // unused op code: empty result
            fin_req = 1'b1;
          end
        endcase
      end
      ST_GET: begin
        fin_req  = 1'b1;
        fin_dens = rdata_q;
        fin_hit  = 1'b1;
      end
      ST_SPLIT: begin
      end
      ST_SAMPLE: begin
        mem_re           = (step_q <= STEP_READ_LAST);
        mem_raddr        = smp_addr;
        mac_ctrl.en      = (step_q != STEP_FIRST) && (step_q != STEP_LAST);
        mac_ctrl.restart = step_q[0];
        if (step_q == STEP_LAST) begin
          fin_req  = 1'b1;
          fin_dens = mac_floor;
          fin_hit  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      step_q    <= STEP_FIRST;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      step_q    <= step_d;
      if (cfg_we_i) begin
        // resolution above MAX_RES saturates
        res_q <= (CW'(cfg_wdata_i) > CW'(MAX_RES)) ? RES_W'(MAX_RES)
                                                   : RES_W'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q <= s_axis_tuser;
      x_q  <= s_axis_tdata[X_LSB +: IDX_W];
      z_q  <= s_axis_tdata[Z_LSB +: IDX_W];
      nd_q <= s_axis_tdata[ND_LSB +: ND_W];
      u_q  <= s_axis_tdata[U_LSB +: COORD_W];
      v_q  <= s_axis_tdata[V_LSB +: COORD_W];
    end
    if (state_q == ST_SPLIT) begin
      x0_q <= fx[FRAC_BITS +: IW];
      z0_q <= fz[FRAC_BITS +: IW];
      tx_q <= fx[FRAC_BITS-1:0];
      tz_q <= fz[FRAC_BITS-1:0];
    end
    if (state_q == ST_SAMPLE && step_q == STEP_TOP) begin
      top_q <= mac_floor;
    end
    if (state_q == ST_SAMPLE && step_q == STEP_BOT) begin
      bot_q <= mac_floor;
    end
  end

  // grid memory, one write and one registered read per cycle; items run one
  // at a time, so a read never meets a write to the same entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_dens_q <= fin_dens;
      out_hit_q  <= fin_hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - DENS_W){1'b0}}, out_dens_q};
  assign m_axis_tuser  = out_hit_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BDG_ASSERT(a_no_accept_in_clear, clk_i, rst_ni,
              (state_q == ST_CLEAR) |-> !s_axis_tready,
              "word accepted during clearing pass")
  `BDG_ASSERT(a_cfg_clears, clk_i, rst_ni,
              cfg_we_i |=> (state_q == ST_CLEAR) && (clr_cnt_q == '0),
              "resolution write did not restart clear")
  `BDG_ASSERT(a_write_source, clk_i, rst_ni,
              mem_we |-> (state_q == ST_CLEAR) ||
                         (state_q == ST_DECODE && op_q == OP_SET && in_range),
              "unexpected grid write")
  `BDG_ASSERT(a_miss_is_zero, clk_i, rst_ni,
              (m_axis_tvalid && !m_axis_tuser) |-> (out_dens_q == '0),
              "miss carries nonzero density")
  `BDG_ASSERT(a_dens_bound, clk_i, rst_ni,
              m_axis_tvalid |-> (out_dens_q <= ONE_FX),
              "density above 1.0")

endmodule

[sv/bdg_mac.sv]
`timescale 1ns / 1ps

module bdg_mac import bdg_pkg::*; (
  input  logic              clk_i,
  input  mac_ctrl_t         ctrl_i,
  input  logic [DENS_W-1:0] a_i,
  input  logic [DENS_W-1:0] b_i,
  output logic [PROD_W-1:0] sum_o
);

  logic [PROD_W-1:0] acc_q;
  logic [PROD_W-1:0] prod;

  assign prod  = PROD_W'(a_i) * PROD_W'(b_i);
  assign sum_o = (ctrl_i.restart ? '0 : acc_q) + prod;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= sum_o;
    end
  end

endmodule

[tb/bilinear_density_grid_tb.sv]
`timescale 1ns / 1ps

module bilinear_density_grid_tb;
  import bdg_pkg::*;

  // op code with no operation behind it: must answer 0 / miss
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned     UNITY       = 32'(ONE_FX);
  // longest accept-to-result time is a sample; leave slack
  localparam int unsigned     SETTLE_CYCLES = 16;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   x;
    logic [IDX_W-1:0]   z;
    logic [ND_W-1:0]    nd;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
  } grid_word_t;

  typedef struct {
    logic [DENS_W-1:0] dens;
    logic              hit;
  } density_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  bilinear_density_grid i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns period, first rising edge at 2 ns
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Grid shadow: our own copy of the density store and resolution register
  // ---------------------------------------------------------------------------
  logic [DENS_W-1:0] grid_shadow [MAX_RES_DEF*MAX_RES_DEF];
  logic [CFG_W-1:0]  res_shadow;

  density_result_t   expected_results[$];

  int unsigned error_count;
  int unsigned results_checked;
  int unsigned settings_used;
  int unsigned op_count [4];

  // idle knobs, in percent chance of starting a burst of idle cycles
  int unsigned gap_pct;
  int unsigned stall_pct;

  // one fixed-point lerp stage, floored
  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned t);
    return (a * (64'(UNITY) - t) + b * t) >> FRAC_BITS;
  endfunction

  // Works out the result of one accepted word and applies its store write.
  function automatic density_result_t predict_density(grid_word_t w);
    density_result_t r;
    int unsigned     res;
    int unsigned     x0, z0, x1, z1;
    longint unsigned u, v, fx, fz, tx, tz, top, bot;
    r.dens = '0;
    r.hit  = 1'b0;
    // register is 7 bits, anything above MAX_RES acts as MAX_RES
    res = (res_shadow > MAX_RES_DEF) ? MAX_RES_DEF : res_shadow;
    if (w.op == OP_SET) begin
      if (w.x < res && w.z < res) begin
        if (w.nd[ND_W-1]) begin
          r.dens = '0;                     // negative clamps to 0
        end else if (w.nd > ND_W'(ONE_FX)) begin
          r.dens = ONE_FX;                 // above 1.0 clamps to 1.0
        end else begin
          r.dens = w.nd[DENS_W-1:0];
        end
        grid_shadow[w.z * res + w.x] = r.dens;
        r.hit = 1'b1;
      end
    end else if (w.op == OP_GET) begin
      if (w.x < res && w.z < res) begin
        r.dens = grid_shadow[w.z * res + w.x];
        r.hit  = 1'b1;
      end
    end else if (w.op == OP_SAMPLE) begin
      if (res != 0) begin
        u  = (w.u > ONE_FX) ? 64'(UNITY) : 64'(w.u);
        v  = (w.v > ONE_FX) ? 64'(UNITY) : 64'(w.v);
        fx = u * (res - 1);
        fz = v * (res - 1);
        x0 = 32'(fx >> FRAC_BITS);
        z0 = 32'(fz >> FRAC_BITS);
        tx = fx & 64'(UNITY - 1);
        tz = fz & 64'(UNITY - 1);
        // far neighbor clamps to the last cell
        x1 = (x0 + 1 < res - 1) ? x0 + 1 : res - 1;
        z1 = (z0 + 1 < res - 1) ? z0 + 1 : res - 1;
        top = blend(grid_shadow[z0 * res + x0], grid_shadow[z0 * res + x1], tx);
        bot = blend(grid_shadow[z1 * res + x0], grid_shadow[z1 * res + x1], tx);
        r.dens = DENS_W'(blend(top, bot, tz));
        r.hit  = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------
  function automatic grid_word_t make_word(logic [OP_W-1:0] op, int unsigned x,
                                           int unsigned z, int nd, int unsigned u,
                                           int unsigned v);
    grid_word_t w;
    w.op = op;
    w.x  = IDX_W'(x);
    w.z  = IDX_W'(z);
    w.nd = ND_W'(nd);
    w.u  = COORD_W'(u);
    w.v  = COORD_W'(v);
    return w;
  endfunction

  // every field random over its full width; callers override what matters
  function automatic grid_word_t random_fields();
    return make_word(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                     $urandom, $urandom);
  endfunction

  // mostly in [0, 1.0], with the ends and over-range values mixed in
  function automatic int unsigned pick_coord();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return UNITY;
    if (r == 2) return $urandom_range(0, 2**COORD_W - 1);
    return $urandom_range(0, UNITY);
  endfunction

  // mostly legal densities, with negatives and over-range values mixed in
  function automatic int pick_density();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 2**ND_W - 1);
    if (r == 1) return UNITY;
    if (r == 2) return 0;
    return $urandom_range(0, UNITY);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint unsigned got,
                                 longint unsigned want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
             want);
    error_count++;
  endtask

  // Values are stable at the falling edge; a word seen valid and ready here
  // transfers at the next rising edge.
  always @(negedge clk_i) begin
    density_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing pending", m_axis_tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[DENS_W-1:0] !== want.dens) begin
          report_mismatch("density_out", m_axis_tdata[DENS_W-1:0], want.dens);
        end
        if (m_axis_tuser !== want.hit) begin
          report_mismatch("hit", m_axis_tuser, want.hit);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure: random bursts of tready low
  // ---------------------------------------------------------------------------
  int unsigned stall_left;

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 7) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------
  // Presents one word and returns at the edge it is taken. tvalid is left
  // high so back-to-back words need no extra assignment; a gap before the next
  // send or a drain lowers it.
  task automatic send_word(grid_word_t w);
    logic took;
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.op;
    s_axis_tdata  <= {4'b0000, w.v, w.u, w.nd, w.z, w.x};
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    expected_results.push_back(predict_density(w));
    op_count[w.op]++;
  endtask

  // Stops sending and waits until every pending result is in, then lets the
  // pipeline settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write only with the block idle; it also kicks off a clear pass,
  // during which the block holds tready low.
  task automatic write_resolution(logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    res_shadow = value;
    foreach (grid_shadow[i]) grid_shadow[i] = '0;
    settings_used++;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Straight out of reset the resolution is 0: everything misses.
  task automatic test_unconfigured_map();
    send_word(make_word(OP_SET, 0, 0, 1000, 0, 0));
    send_word(make_word(OP_GET, 0, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, 32768, 32768));
    send_word(make_word(OP_RESERVED, 0, 0, 0, 0, 0));
  endtask

  // 4x4 grid: clamping, readback, range misses, sample corners and saturation
  task automatic test_set_get_sample_basics();
    write_resolution(4);
    send_word(make_word(OP_SET, 0, 0, UNITY, 0, 0));
    send_word(make_word(OP_SET, 3, 0, 2**(ND_W-1) - 1, 0, 0));  // over 1.0
    send_word(make_word(OP_SET, 0, 3, -1, 0, 0));                // slightly negative
    send_word(make_word(OP_SET, 3, 3, -(2**(ND_W-1)), 0, 0));    // most negative
    send_word(make_word(OP_SET, 1, 1, 12345, 0, 0));
    send_word(make_word(OP_SET, 4, 0, 500, 0, 0));               // just past the edge
    send_word(make_word(OP_SET, 0, 2**IDX_W - 1, 500, 0, 0));
    send_word(make_word(OP_GET, 0, 0, 0, 0, 0));
    send_word(make_word(OP_GET, 3, 0, 0, 0, 0));
    send_word(make_word(OP_GET, 3, 3, 0, 0, 0));
    send_word(make_word(OP_GET, 1, 1, 0, 0, 0));
    send_word(make_word(OP_GET, 2**IDX_W - 1, 2**IDX_W - 1, 0, 0, 0));
    send_word(make_word(OP_GET, 3, 4, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, UNITY, UNITY));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, 2**COORD_W - 1, 2**COORD_W - 1));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, 32768, 21845));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, UNITY, 0));
    send_word(make_word(OP_RESERVED, 2**IDX_W - 1, 2**IDX_W - 1, -1, 2**COORD_W - 1,
                        2**COORD_W - 1));
  endtask

  // Single-cell grid, saturated register value, and explicit clear to 0
  task automatic test_resolution_extremes();
    write_resolution(1);
    send_word(make_word(OP_SET, 0, 0, 40000, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, pick_coord(), pick_coord()));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, UNITY, UNITY));
    send_word(make_word(OP_GET, 1, 0, 0, 0, 0));
    write_resolution(CFG_W'(2**CFG_W - 1));   // acts as MAX_RES
    send_word(make_word(OP_SET, 63, 63, UNITY, 0, 0));
    send_word(make_word(OP_SET, 0, 63, 777, 0, 0));
    send_word(make_word(OP_GET, 63, 63, 0, 0, 0));
    send_word(make_word(OP_GET, 64, 0, 0, 0, 0));
    send_word(make_word(OP_SET, 64, 64, 999, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, UNITY, UNITY));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, UNITY - 1, 1));
    write_resolution(0);
    send_word(make_word(OP_GET, 0, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, 0, 0));
  endtask

  // Random traffic on one resolution: mostly in-range sets, gets and samples
  // so the grid fills up and samples see real data; the rest is noise.
  task automatic test_random_traffic(logic [CFG_W-1:0] res, int unsigned words,
                                     int unsigned gaps, int unsigned stalls);
    int unsigned eff;
    int unsigned pick;
    grid_word_t  w;
    write_resolution(res);
    gap_pct   = gaps;
    stall_pct = stalls;
    eff = (res > MAX_RES_DEF) ? MAX_RES_DEF : res;
    for (int unsigned i = 0; i < words; i++) begin
      // hold off now and then until the block has answered everything
      if (i == words / 2 || $urandom_range(0, 99) == 0) wait_drained();
      w    = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        w.op = OP_SET;
        w.x  = IDX_W'($urandom_range(0, eff - 1));
        w.z  = IDX_W'($urandom_range(0, eff - 1));
        w.nd = ND_W'(pick_density());
      end else if (pick < 55) begin
        w.op = OP_GET;
        w.x  = IDX_W'($urandom_range(0, eff - 1));
        w.z  = IDX_W'($urandom_range(0, eff - 1));
      end else if (pick < 90) begin
        w.op = OP_SAMPLE;
        w.u  = COORD_W'(pick_coord());
        w.v  = COORD_W'(pick_coord());
      end else if ($urandom_range(0, 1) == 1) begin
        // one index sitting right on the edge
        if ($urandom_range(0, 1) == 1) w.x = IDX_W'(eff);
        else w.z = IDX_W'(eff);
      end
      send_word(w);
    end
  endtask

  // Last stretch: no idling on either side, words back to back
  task automatic test_back_to_back(int unsigned words);
    grid_word_t w;
    gap_pct   = 0;
    stall_pct = 0;
    for (int unsigned i = 0; i < words; i++) begin
      w = random_fields();
      if (w.op != OP_SAMPLE) begin
        w.x = IDX_W'($urandom_range(0, MAX_RES_DEF - 1));
        w.z = IDX_W'($urandom_range(0, MAX_RES_DEF - 1));
      end
      send_word(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    res_shadow = '0;
    foreach (grid_shadow[i]) grid_shadow[i] = '0;
    gap_pct   = 20;
    stall_pct = 20;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_unconfigured_map();
    test_set_get_sample_basics();
    test_resolution_extremes();
    test_random_traffic(2, 220, 20, 20);
    test_random_traffic(3, 220, 40, 0);
    test_random_traffic(8, 220, 0, 40);
    test_random_traffic(17, 220, 10, 10);
    test_random_traffic(CFG_W'($urandom_range(5, 63)), 220, 0, 0);
    test_random_traffic(64, 220, 30, 25);
    test_random_traffic(CFG_W'(2**CFG_W - 1), 220, 15, 30);
    test_back_to_back(200);
    wait_drained();

    $display("Covered %0d set, %0d get, %0d sample and %0d unused-op words",
             op_count[OP_SET], op_count[OP_GET], op_count[OP_SAMPLE],
             op_count[OP_RESERVED]);
    $display("across %0d resolution writes; %0d result words checked",
             settings_used, results_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run including all clear passes
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
